// File: hdl/weighted_palindromic_tree_assert.svh
// Assertion macros for the weighted palindromic tree.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef WEIGHTED_PALINDROMIC_TREE_ASSERT_SVH
`define WEIGHTED_PALINDROMIC_TREE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WPT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("weighted_palindromic_tree check failed");
`define WPT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("weighted_palindromic_tree check failed");
`define WPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("weighted_palindromic_tree check failed");
`else
`define WPT_ASSERT(label, prop)
`define WPT_ASSERT_IMPL(label, ante, cons)
`define WPT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/wpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wpt_pkg;

   localparam int MAX_CHARS  = 4096;
   localparam int ALPHABET   = 26;
   localparam int NODE_CAP   = MAX_CHARS + 2;
   localparam int TEXT_DEPTH = MAX_CHARS + 1;
   localparam int EDGE_DEPTH = NODE_CAP * ALPHABET;
   localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
   localparam int NODE_W     = 13;
   localparam int LEN_W      = 14;
   localparam int COST_W     = 28;
   localparam int LETTER_W   = 5;
   localparam int WEIGHT_W   = 16;

   localparam logic [NODE_W-1:0] NODE_EMPTY = 13'd0;
   localparam logic [NODE_W-1:0] NODE_IMAG  = 13'd1;
   localparam logic signed [COST_W-1:0] COST_MAX = 28'sh7FFFFFF;
   localparam logic signed [COST_W-1:0] COST_MIN = 28'sh8000000;

   typedef struct packed {
      logic [LETTER_W-1:0]        letter;
      logic signed [WEIGHT_W-1:0] letter_weight;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]        suffix_node;
      logic [NODE_W-1:0]        suffix_length;
      logic signed [COST_W-1:0] suffix_cost;
      logic                     created;
      logic signed [COST_W-1:0] best_cost;
      logic                     full_res;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_LEN,
      ST_WALK_CMP,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_LINK_RD,
      ST_LINK_CHK,
      ST_FIN,
      ST_NODE_RD,
      ST_NODE_CHK,
      ST_DONE
   } state_type;

   // Flat edge table address: one row of letters per node
   function automatic logic [EDGE_AW-1:0] edge_addr(input logic [NODE_W-1:0] node,
                                                    input logic [LETTER_W-1:0] letter);
      edge_addr = EDGE_AW'(node) * EDGE_AW'(ALPHABET) + EDGE_AW'(letter);
   endfunction

   // Clamp a widened cost sum to the cost range
   function automatic logic signed [COST_W-1:0] sat_cost(input logic signed [COST_W:0] x);
      logic signed [COST_W:0] hi;
      logic signed [COST_W:0] lo;
      hi = {COST_MAX[COST_W-1], COST_MAX};
      lo = {COST_MIN[COST_W-1], COST_MIN};
      if (x > hi) begin
         sat_cost = COST_MAX;
      end else if (x < lo) begin
         sat_cost = COST_MIN;
      end else begin
         sat_cost = x[COST_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

// File: hdl/wpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module wpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read one entry into a register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: hdl/weighted_palindromic_tree.sv
//  channel   | signals                      | payload
//  ----------+------------------------------+---------------------------------
//  request   | req_valid / req_ready        | req_payload  (letter, weight)
//  response  | rsp_valid / rsp_ready        | rsp_payload  (suffix node, ...)
//
//  After reset the edge table is cleared one entry a cycle, all 106548 entries,
//  with req_ready low. An item then follows suffix-link hops, with a second walk
//  when a new node has a real parent; each hop waits on registered reads.
//  Ignored letters skip the walk and go straight to the result.
//  The result sits in an output register; a new request is taken while it waits,
//  and the block stalls at the end of that item until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_palindromic_tree_assert.svh"
module weighted_palindromic_tree
   import wpt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   state_type state_ff, state_in;

   logic [EDGE_AW-1:0]        clr_ff, clr_in;
   logic [LETTER_W-1:0]       letter_ff, letter_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [NODE_W-1:0]         text_count_ff, text_count_in;
   logic [NODE_W-1:0]         pos_ff, pos_in;
   logic [NODE_W-1:0]         node_count_ff, node_count_in;
   logic [NODE_W-1:0]         last_node_ff, last_node_in;
   logic [NODE_W-1:0]         last_len_ff, last_len_in;
   logic signed [COST_W-1:0]  last_cost_ff, last_cost_in;
   logic signed [COST_W-1:0]  best_ff, best_in;
   logic [NODE_W-1:0]         v_ff, v_in;
   logic signed [LEN_W-1:0]   len_ff, len_in;
   logic [NODE_W-1:0]         link_ff, link_in;
   logic                      phase_ff, phase_in;
   logic [NODE_W-1:0]         par_ff, par_in;
   logic signed [LEN_W-1:0]   par_len_ff, par_len_in;
   logic signed [COST_W-1:0]  new_cost_ff, new_cost_in;
   logic [NODE_W-1:0]         lk_ff, lk_in;
   logic                      made_ff, made_in;
   logic                      full_ff, full_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   // memory ports
   logic                  text_we;
   logic [NODE_W-1:0]     text_waddr, text_raddr;
   logic [LETTER_W-1:0]   text_rd;
   logic                  node_we;
   logic [NODE_W-1:0]     node_raddr, cost_raddr;
   logic [LEN_W-1:0]      len_rd;
   logic [NODE_W-1:0]     link_rd;
   logic [COST_W-1:0]     cost_rd;
   logic                  edge_we;
   logic [EDGE_AW-1:0]    edge_waddr, edge_raddr;
   logic [NODE_W-1:0]     edge_wdata, edge_rd;

   // walk and creation datapath
   logic                      req_xfer, item_full, item_ok;
   logic signed [LEN_W-1:0]   cur_len, chk_len;
   logic [NODE_W-1:0]         cur_link;
   logic signed [LEN_W:0]     q_pos;
   logic signed [COST_W-1:0]  par_cost, chk_cost;
   logic signed [COST_W:0]    cost_add, cost_sum;
   logic                      edge_missing;
   logic signed [LEN_W-1:0]   new_len;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign item_full = (text_count_ff > NODE_W'(MAX_CHARS));
   assign item_ok   = !item_full && (req_payload.letter < LETTER_W'(ALPHABET));

   // Fixed values of the two roots, memory for all other nodes
   assign cur_len  = (v_ff == NODE_EMPTY) ? '0 :
                     (v_ff == NODE_IMAG) ? -14'sd1 : $signed(len_rd);
   assign cur_link = (v_ff == NODE_EMPTY || v_ff == NODE_IMAG) ? NODE_IMAG : link_rd;
   assign q_pos    = $signed({2'b00, pos_ff}) - $signed({cur_len[LEN_W-1], cur_len})
                     - 15'sd1;
   assign par_cost = (par_ff == NODE_EMPTY || par_ff == NODE_IMAG) ? '0 : $signed(cost_rd);
   assign cost_add = par_len_ff[LEN_W-1] ? (COST_W+1)'(weight_ff)
                                         : (COST_W+1)'(weight_ff) <<< 1;
   assign cost_sum = $signed({par_cost[COST_W-1], par_cost}) + cost_add;
   assign edge_missing = (edge_rd == '0) && (node_count_ff < NODE_W'(NODE_CAP));
   assign new_len  = par_len_ff + 14'sd2;
   assign chk_len  = (last_node_ff == NODE_EMPTY) ? '0 :
                     (last_node_ff == NODE_IMAG) ? -14'sd1 : $signed(len_rd);
   assign chk_cost = (last_node_ff == NODE_EMPTY || last_node_ff == NODE_IMAG) ? '0 :
                     $signed(cost_rd);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == EDGE_AW'(EDGE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = item_ok ? ST_WALK_RD : ST_DONE;
            end
         end
         ST_WALK_RD: state_in = ST_WALK_LEN;
         ST_WALK_LEN: begin
            priority if (cur_len[LEN_W-1]) begin
               state_in = phase_ff ? ST_LINK_RD : ST_EDGE_RD;
            end else if (q_pos <= 0) begin
               state_in = ST_WALK_RD;
            end else begin
               state_in = ST_WALK_CMP;
            end
         end
         ST_WALK_CMP: begin
            if (text_rd == letter_ff) begin
               state_in = phase_ff ? ST_LINK_RD : ST_EDGE_RD;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_EDGE_RD: state_in = ST_EDGE_CHK;
         ST_EDGE_CHK: begin
            priority if (!edge_missing) begin
               state_in = ST_NODE_RD;
            end else if (par_len_ff[LEN_W-1]) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_LINK_RD:  state_in = ST_LINK_CHK;
         ST_LINK_CHK: state_in = ST_FIN;
         ST_FIN:      state_in = ST_DONE;
         ST_NODE_RD:  state_in = ST_NODE_CHK;
         ST_NODE_CHK: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory control
   always_comb begin
      text_we    = 1'b0;
      text_waddr = text_count_ff;
      text_raddr = q_pos[NODE_W-1:0];
      node_we    = 1'b0;
      node_raddr = (state_ff == ST_NODE_RD) ? last_node_ff : v_ff;
      cost_raddr = (state_ff == ST_NODE_RD) ? last_node_ff : par_ff;
      edge_we    = 1'b0;
      edge_waddr = edge_addr(par_ff, letter_ff);
      edge_wdata = node_count_ff;
      edge_raddr = (state_ff == ST_LINK_RD) ? edge_addr(v_ff, letter_ff)
                                            : edge_addr(par_ff, letter_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            edge_we    = 1'b1;
            edge_waddr = clr_ff;
            edge_wdata = '0;
         end
         ST_IDLE: begin
            text_we = req_xfer && item_ok;
         end
         ST_FIN: begin
            node_we = 1'b1;
            edge_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath registers
   always_comb begin
      clr_in        = clr_ff;
      letter_in     = letter_ff;
      weight_in     = weight_ff;
      text_count_in = text_count_ff;
      pos_in        = pos_ff;
      node_count_in = node_count_ff;
      last_node_in  = last_node_ff;
      last_len_in   = last_len_ff;
      last_cost_in  = last_cost_ff;
      best_in       = best_ff;
      v_in          = v_ff;
      len_in        = len_ff;
      link_in       = link_ff;
      phase_in      = phase_ff;
      par_in        = par_ff;
      par_len_in    = par_len_ff;
      new_cost_in   = new_cost_ff;
      lk_in         = lk_ff;
      made_in       = made_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               letter_in = req_payload.letter;
               weight_in = req_payload.letter_weight;
               full_in   = item_full;
               made_in   = 1'b0;
               phase_in  = 1'b0;
               v_in      = last_node_ff;
               pos_in    = text_count_ff;
               if (item_ok) begin
                  text_count_in = text_count_ff + 1'b1;
               end
            end
         end
         ST_WALK_LEN: begin
            len_in  = cur_len;
            link_in = cur_link;
            if (cur_len[LEN_W-1]) begin
               if (!phase_ff) begin
                  par_in     = v_ff;
                  par_len_in = cur_len;
               end
            end else if (q_pos <= 0) begin
               v_in = cur_link;
            end
         end
         ST_WALK_CMP: begin
            if (text_rd == letter_ff) begin
               if (!phase_ff) begin
                  par_in     = v_ff;
                  par_len_in = len_ff;
               end
            end else begin
               v_in = link_ff;
            end
         end
         ST_EDGE_CHK: begin
            new_cost_in = sat_cost(cost_sum);
            lk_in       = '0;
            if (!edge_missing) begin
               last_node_in = edge_rd;
            end else if (!par_len_ff[LEN_W-1]) begin
               // second walk from the parent's suffix link
               v_in     = link_ff;
               phase_in = 1'b1;
            end
         end
         ST_LINK_CHK: begin
            lk_in = edge_rd;
         end
         ST_FIN: begin
            node_count_in = node_count_ff + 1'b1;
            last_node_in  = node_count_ff;
            last_len_in   = new_len[NODE_W-1:0];
            last_cost_in  = new_cost_ff;
            made_in       = 1'b1;
            if (new_cost_ff > best_ff) begin
               best_in = new_cost_ff;
            end
         end
         ST_NODE_CHK: begin
            last_len_in  = chk_len[NODE_W-1:0];
            last_cost_in = chk_cost;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.suffix_node    = last_node_ff;
               rsp_in.suffix_length  = last_len_ff;
               rsp_in.suffix_cost    = last_cost_ff;
               rsp_in.created        = made_ff;
               rsp_in.best_cost      = best_ff;
               rsp_in.full_res       = full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         text_count_ff <= 13'd1;
         node_count_ff <= 13'd2;
         last_node_ff  <= NODE_EMPTY;
         last_len_ff   <= '0;
         last_cost_ff  <= '0;
         best_ff       <= COST_MIN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         text_count_ff <= text_count_in;
         node_count_ff <= node_count_in;
         last_node_ff  <= last_node_in;
         last_len_ff   <= last_len_in;
         last_cost_ff  <= last_cost_in;
         best_ff       <= best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working payload registers
   always_ff @(posedge clock) begin
      letter_ff   <= letter_in;
      weight_ff   <= weight_in;
      pos_ff      <= pos_in;
      v_ff        <= v_in;
      len_ff      <= len_in;
      link_ff     <= link_in;
      phase_ff    <= phase_in;
      par_ff      <= par_in;
      par_len_ff  <= par_len_in;
      new_cost_ff <= new_cost_in;
      lk_ff       <= lk_in;
      made_ff     <= made_in;
      full_ff     <= full_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   wpt_ram #(.WIDTH(LETTER_W), .DEPTH(TEXT_DEPTH)) u_text (
      .clock   (clock),
      .wr_en   (text_we),
      .wr_addr (text_waddr),
      .wr_data (req_payload.letter),
      .rd_addr (text_raddr),
      .rd_data (text_rd)
   );

   wpt_ram #(.WIDTH(LEN_W), .DEPTH(NODE_CAP)) u_len (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_count_ff),
      .wr_data (new_len),
      .rd_addr (node_raddr),
      .rd_data (len_rd)
   );

   wpt_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_link (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_count_ff),
      .wr_data (lk_ff),
      .rd_addr (node_raddr),
      .rd_data (link_rd)
   );

   wpt_ram #(.WIDTH(COST_W), .DEPTH(NODE_CAP)) u_cost (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_count_ff),
      .wr_data (new_cost_ff),
      .rd_addr (cost_raddr),
      .rd_data (cost_rd)
   );

   wpt_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_edge (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_addr (edge_raddr),
      .rd_data (edge_rd)
   );

   `WPT_ASSERT(a_node_count_range, node_count_ff >= 13'd2 && node_count_ff <= NODE_W'(NODE_CAP))
   `WPT_ASSERT_IMPL(a_fin_real_node, state_ff == ST_FIN, node_count_ff >= 13'd2 && !full_ff)
   `WPT_ASSERT_NEXT(a_text_advance, req_xfer && item_ok, text_count_ff == $past(text_count_ff) + 13'd1)
   `WPT_ASSERT_IMPL(a_full_no_create, rsp_valid_ff && rsp_ff.full_res, !rsp_ff.created)

endmodule
`default_nettype wire
